>>> src/steno_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steno_pkg
// Shared types, constants and helpers for the steno chord encoder.
// ----------------------------------------------------------------------------
package steno_pkg;

  localparam int NUM_KEYS   = 42;
  localparam int HIST_DEPTH = 8;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
  localparam int TIME_W     = 16;

  localparam logic [5:0]        HELD_MAX    = 6'd63;
  localparam logic [TIME_W-1:0] MIN_AUTO_MS = TIME_W'(1000 / 50);

  localparam logic [1:0] REQ_KEY      = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_HIST_CLR = 2'd2;

  localparam logic REG_FIRST_UP = 1'b0;
  localparam logic REG_REPEAT   = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] key_index;
    logic       key_pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic first_up_mode;
    logic repeat_enable;
  } cfg_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] chord;
    logic [TIME_W-1:0]   stamp;
  } hist_entry_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ITEM, OP_RD_NEW, OP_GAP, OP_TR_RD, OP_TR_CHK, OP_FD_INIT,
    OP_FD_RD, OP_FD_CHK, OP_REP_RD, OP_REP_LD, OP_PKT, OP_BYTE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_GAP, S_TR_RD, S_TR_CHK, S_FD_INIT, S_FD_RD,
    S_FD_CHK, S_REP, S_REP_LD, S_PKT, S_BYTE
  } state_t;

  typedef struct packed {
    logic send;
    logic tick_go;
    logic trim_go;
    logic per_zero;
    logic idx_zero;
    logic idx_done;
    logic dt_bad;
    logic match;
    logic rep_go;
    logic out_free;
    logic byte_last;
  } status_t;

  // key k sits at bit 7*(k/7) + 6 - k%7; k/7 by reciprocal (exact for k < 56)
  function automatic logic [NUM_KEYS-1:0] key_mask(input logic [5:0] k);
    logic [11:0] prod;
    logic [2:0]  q;
    logic [5:0]  q7;
    logic [5:0]  r;
    logic [5:0]  pos;
    prod = {6'd0, k} * 12'd37;
    q    = prod[10:8];
    q7   = {3'd0, q} * 6'd7;
    r    = k - q7;
    pos  = q7 + 6'd6 - r;
    return NUM_KEYS'(1) << pos;
  endfunction

endpackage

>>> src/steno_chord_encoder_with_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steno_chord_encoder_with_repeat
// Steno chord encoder emitting six-byte Gemini PR packets, with auto repeat.
// ----------------------------------------------------------------------------
// One request at a time. A key press, history clear or tick without repeat
// work goes through idle and decide; a request that sends a chord adds the
// packet state and one packet byte per cycle (6 bytes, longer if the output
// stalls). A tick with repeat work may scan the 8-entry chord history through
// its single read port, reading then checking each entry, in a trim pass
// and a search pass, plus the packet when a repeat fires. The last byte
// may sit in the output register while the next request is taken.
module steno_chord_encoder_with_repeat (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  steno_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output steno_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import steno_pkg::*;

  cfg_t    cfg;
  status_t st;
  op_t     op;
  logic    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FIRST_UP: cfg.first_up_mode <= pwdata[0];
        REG_REPEAT:   cfg.repeat_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_UP: prdata = {31'd0, cfg.first_up_mode};
      REG_REPEAT:   prdata = {31'd0, cfg.repeat_enable};
      default:      prdata = '0;
    endcase
  end

  steno_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  steno_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op        (op),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/steno_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steno_ctrl
// Sequencer: steps the datapath through key, tick and packet operations.
// ----------------------------------------------------------------------------
module steno_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  steno_pkg::status_t st,
  output steno_pkg::op_t     op
);
  import steno_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_ITEM;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.send) begin
          state_next = S_PKT;
        end else if (st.tick_go) begin
          op         = OP_RD_NEW;
          state_next = S_GAP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_GAP: begin
        op = OP_GAP;
        if (st.trim_go && !st.per_zero) state_next = S_TR_RD;
        else if (st.trim_go)            state_next = S_FD_INIT;
        else                            state_next = S_REP;
      end
      S_TR_RD: begin
        if (st.idx_zero) begin
          state_next = S_FD_INIT;
        end else begin
          op         = OP_TR_RD;
          state_next = S_TR_CHK;
        end
      end
      S_TR_CHK: begin
        op         = OP_TR_CHK;
        state_next = st.dt_bad ? S_FD_INIT : S_TR_RD;
      end
      S_FD_INIT: begin
        op         = OP_FD_INIT;
        state_next = S_FD_RD;
      end
      S_FD_RD: begin
        if (st.idx_done) begin
          state_next = S_REP;
        end else begin
          op         = OP_FD_RD;
          state_next = S_FD_CHK;
        end
      end
      S_FD_CHK: begin
        op         = OP_FD_CHK;
        state_next = st.match ? S_REP : S_FD_RD;
      end
      S_REP: begin
        if (st.rep_go) begin
          op         = OP_REP_RD;
          state_next = S_REP_LD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REP_LD: begin
        op         = OP_REP_LD;
        state_next = S_PKT;
      end
      S_PKT: begin
        op         = OP_PKT;
        state_next = S_BYTE;
      end
      S_BYTE: begin
        if (st.out_free) begin
          op = OP_BYTE;
          if (st.byte_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/steno_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steno_dp
// Key sets, timers, chord history memory and packet output register.
// ----------------------------------------------------------------------------
module steno_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  steno_pkg::cfg_t      cfg,
  input  steno_pkg::op_t       op,
  input  steno_pkg::in_item_t  in_data,
  output steno_pkg::status_t   st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output steno_pkg::out_item_t out_data
);
  import steno_pkg::*;

  logic [NUM_KEYS-1:0] held_keys, chord_keys, ignored_keys, pkt;
  logic [5:0]          held_count;
  logic [TIME_W-1:0]   now_ms, last_change_ms, last_press_ms, repeat_period;
  logic [TIME_W-1:0]   hold, gap, lo;
  logic [TIME_W:0]     hi;
  logic [HIST_AW-1:0]  hist_first, hist_newest, repeat_pos;
  logic [HIST_CW-1:0]  hist_count, idx;
  logic [2:0]          byte_cnt;
  logic                send, tick_go, save_pend;

  hist_entry_t         hist_mem [HIST_DEPTH];
  hist_entry_t         rd_q;
  logic [HIST_AW-1:0]  rd_addr, wr_addr;
  logic                rd_en, wr_en;

  logic [NUM_KEYS-1:0] kbit;
  logic                key_ok;
  logic [5:0]          held_count_dec;
  logic [HIST_CW-1:0]  idx_m1;
  logic [TIME_W-1:0]   hold_now, gap_now, dt, per_q;
  logic [HIST_CW-1:0]  pos_inc;
  logic                item_send, item_tick;

  assign kbit           = key_mask(in_data.key_index);
  assign key_ok         = in_data.key_index < 6'(NUM_KEYS);
  assign held_count_dec = (held_count != 6'd0) ? held_count - 6'd1 : held_count;
  assign idx_m1         = idx - HIST_CW'(1);
  assign hold_now       = now_ms - last_change_ms;
  assign gap_now        = last_press_ms - rd_q.stamp;
  assign dt             = last_press_ms - rd_q.stamp;
  assign per_q          = (gap >> 2) < MIN_AUTO_MS ? MIN_AUTO_MS : (gap >> 2);
  assign pos_inc        = {1'b0, repeat_pos} + HIST_CW'(1);

  // release that sends: first-up on a non-ignored key, else last key up
  assign item_send = (in_data.req_type == REQ_KEY) && key_ok && !in_data.key_pressed &&
                     (cfg.first_up_mode ? ((ignored_keys & kbit) == '0)
                                        : (held_count_dec == '0));
  assign item_tick = (in_data.req_type == REQ_TICK) && cfg.repeat_enable &&
                     (held_count != '0) && (hist_count != '0);

  // history ring: one read port, one write port
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = hist_newest;
    unique case (op)
      OP_RD_NEW: rd_addr = hist_newest;
      OP_TR_RD:  rd_addr = hist_first + idx_m1[HIST_AW-1:0];
      OP_FD_RD:  rd_addr = hist_first + idx[HIST_AW-1:0];
      OP_REP_RD: rd_addr = hist_first + repeat_pos;
      default:   rd_en   = 1'b0;
    endcase
    wr_en   = (op == OP_PKT) && save_pend;
    wr_addr = (hist_count >= HIST_CW'(HIST_DEPTH)) ? hist_first
                                                   : hist_first + hist_count[HIST_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= '{chord: chord_keys, stamp: last_press_ms};
    if (rd_en) rd_q <= hist_mem[rd_addr];
  end

  always_comb begin
    st.send      = send;
    st.tick_go   = tick_go;
    st.trim_go   = (repeat_period == '0) && (hold_now >= gap_now);
    st.per_zero  = gap_now == '0;
    st.idx_zero  = idx == '0;
    st.idx_done  = idx >= hist_count;
    st.dt_bad    = (dt < lo) || ({1'b0, dt} > hi);
    st.match     = rd_q.chord == held_keys;
    st.rep_go    = (repeat_period != '0) && (hold >= repeat_period);
    st.out_free  = !out_valid || out_ready;
    st.byte_last = byte_cnt == 3'd5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_keys      <= '0;
      chord_keys     <= '0;
      ignored_keys   <= '0;
      held_count     <= '0;
      now_ms         <= '0;
      last_change_ms <= '0;
      last_press_ms  <= '0;
      repeat_period  <= '0;
      hist_first     <= '0;
      hist_count     <= '0;
      hist_newest    <= '0;
      repeat_pos     <= '0;
      send           <= 1'b0;
      tick_go        <= 1'b0;
      save_pend      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_ready && op != OP_BYTE) out_valid <= 1'b0;
      unique case (op)
        OP_ITEM: begin
          send      <= item_send;
          tick_go   <= item_tick;
          save_pend <= item_send && cfg.repeat_enable;
          priority if (in_data.req_type == REQ_KEY) begin
            if (key_ok) begin
              last_change_ms <= now_ms;
              repeat_period  <= '0;
              if (in_data.key_pressed) begin
                last_press_ms <= now_ms;
                held_keys     <= held_keys | kbit;
                chord_keys    <= chord_keys | kbit;
                if (held_count < HELD_MAX) held_count <= held_count + 6'd1;
              end else begin
                held_keys  <= held_keys & ~kbit;
                held_count <= held_count_dec;
                if (cfg.first_up_mode) begin
                  chord_keys   <= held_keys;
                  ignored_keys <= ignored_keys & ~kbit;
                end
              end
            end
          end else if (in_data.req_type == REQ_TICK) begin
            now_ms <= now_ms + TIME_W'(1);
          end else if (in_data.req_type == REQ_HIST_CLR) begin
            ignored_keys  <= '0;
            hist_first    <= '0;
            hist_count    <= '0;
            hist_newest   <= '0;
            repeat_pos    <= '0;
            repeat_period <= '0;
          end else begin
          end
        end
        OP_GAP: begin
          hold <= hold_now;
          gap  <= gap_now;
          lo   <= gap_now - (gap_now >> 1);
          hi   <= {1'b0, gap_now} + {2'b0, gap_now[TIME_W-1:1]};
          idx  <= hist_count;
        end
        OP_TR_CHK: begin
          if (st.dt_bad) begin
            hist_first <= hist_first + idx[HIST_AW-1:0];
            hist_count <= hist_count - idx;
          end else begin
            last_press_ms <= rd_q.stamp;
            idx           <= idx_m1;
          end
        end
        OP_FD_INIT: idx <= '0;
        OP_FD_CHK: begin
          if (st.match) begin
            hist_first    <= hist_first + idx[HIST_AW-1:0];
            hist_count    <= hist_count - idx;
            repeat_pos    <= '0;
            repeat_period <= per_q;
            if (cfg.first_up_mode) ignored_keys <= held_keys;
          end else begin
            idx <= idx + HIST_CW'(1);
          end
        end
        OP_REP_LD: begin
          chord_keys     <= rd_q.chord;
          repeat_pos     <= (pos_inc >= hist_count) ? '0 : pos_inc[HIST_AW-1:0];
          last_change_ms <= now_ms;
        end
        OP_PKT: begin
          if (save_pend) begin
            hist_newest <= wr_addr;
            if (hist_count >= HIST_CW'(HIST_DEPTH)) hist_first <= hist_first + HIST_AW'(1);
            else                                    hist_count <= hist_count + HIST_CW'(1);
          end
          save_pend  <= 1'b0;
          send       <= 1'b0;
          pkt        <= chord_keys;
          byte_cnt   <= '0;
          if (cfg.first_up_mode) ignored_keys <= held_keys;
          held_keys  <= '0;
          chord_keys <= '0;
        end
        OP_BYTE: begin
          out_valid            <= 1'b1;
          out_data.packet_byte <= {byte_cnt == 3'd0, pkt[6:0]};
          out_data.last_byte   <= byte_cnt == 3'd5;
          pkt                  <= pkt >> 7;
          byte_cnt             <= byte_cnt + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
